// File: src/nnsa_pkg.sv
// ----------------------------------------------------------------------------
// nnsa_pkg
// shared widths, size clamp, register indexes and controller/datapath structs
// ----------------------------------------------------------------------------
package nnsa_pkg;

   localparam int DIM_W   = 13;  // size registers and error terms
   localparam int COORD_W = 12;  // destination coordinates
   localparam int OFF_W   = 25;  // source offset and row skip
   localparam int IDX_W   = 24;  // source raster index
   localparam int CNT_W   = 4;   // divider iteration counter

   localparam int MAX_DIM = 4096;
   localparam int DIM_CAP = (MAX_DIM < 4096) ? MAX_DIM : 4096;
   localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_W'(DIM_CAP);

   // register indexes
   localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
   localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

   typedef struct packed {
      logic div_start;  // launch a division
      logic div_row;    // operands of the launched division: row axis
      logic load_col;   // latch column whole and remainder steps
      logic load_row;   // latch row quotient and remainder
      logic load_skip;  // latch row skip
      logic step;       // emit one pixel and advance the walk
      logic clear;      // walk starts from pixel 0 for this step
   } nnsa_cmd_type;

   typedef struct packed {
      logic div_done;
   } nnsa_status_type;

   // zero reads as one, oversize saturates at the cap
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_CAP_V) begin
         r = DIM_CAP_V;
      end
      return r;
   endfunction

endpackage

// File: src/nnsa_div.sv
// ----------------------------------------------------------------------------
// nnsa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nnsa_div
   import nnsa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIM_W-1:0] numer,
   input  logic [DIM_W-1:0] denom,
   output logic             done,
   output logic [DIM_W-1:0] quot,
   output logic [DIM_W-1:0] rem
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             done_ff, done_in;
   logic [DIM_W-1:0] quot_ff, quot_in;
   logic [DIM_W-1:0] rem_ff, rem_in;
   logic [DIM_W:0]   shifted;
   logic [DIM_W:0]   diff;
   logic             ge;

   assign shifted = {rem_ff, quot_ff[DIM_W-1]};
   assign diff    = shifted - {1'b0, denom};
   assign ge      = (shifted >= {1'b0, denom});

   always_comb begin
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      done_in  = (count_ff == CNT_W'(1)) && !start;
      if (start) begin
         count_in = CNT_W'(DIM_W);
         quot_in  = numer;
         rem_in   = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - CNT_W'(1);
         quot_in  = {quot_ff[DIM_W-2:0], ge};
         rem_in   = ge ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// File: src/nnsa_dp.sv
// ----------------------------------------------------------------------------
// nnsa_dp
// step registers, error-accumulating walk and result register
// ----------------------------------------------------------------------------
module nnsa_dp
   import nnsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  nnsa_cmd_type       cmd,
   output nnsa_status_type    status,
   input  logic [DIM_W-1:0]   src_width,
   input  logic [DIM_W-1:0]   src_height,
   input  logic [DIM_W-1:0]   dst_width,
   input  logic [DIM_W-1:0]   dst_height,
   output logic [IDX_W-1:0]   source_index,
   output logic [COORD_W-1:0] dest_x,
   output logic [COORD_W-1:0] dest_y,
   output logic               last_pixel
);

   logic [DIM_W-1:0] sw, sh, dw, dh;
   logic [DIM_W-1:0] div_quot, div_rem;
   logic             div_done;

   // steps
   logic [DIM_W-1:0] col_whole_ff, col_whole_in;
   logic [DIM_W-1:0] col_rem_ff, col_rem_in;
   logic [DIM_W-1:0] row_rem_ff, row_rem_in;
   logic [DIM_W-1:0] row_quot_ff, row_quot_in;
   logic [OFF_W-1:0] row_skip_ff, row_skip_in;
   logic [2*DIM_W-1:0] skip_prod;

   // walk
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0]   cerr_ff, cerr_in;
   logic [DIM_W-1:0]   rerr_ff, rerr_in;

   logic [OFF_W-1:0]   cur_off;
   logic [COORD_W-1:0] cur_col, cur_row;
   logic [DIM_W-1:0]   cur_cerr, cur_rerr;
   logic               row_end, last;
   logic [DIM_W-1:0]   cerr_sum, rerr_sum;
   logic               cc, rc;
   logic [OFF_W-1:0]   off_sum;

   // result
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COORD_W-1:0] dx_ff, dx_in;
   logic [COORD_W-1:0] dy_ff, dy_in;
   logic               last_ff, last_in;

   assign sw = eff_dim(src_width);
   assign sh = eff_dim(src_height);
   assign dw = eff_dim(dst_width);
   assign dh = eff_dim(dst_height);

   nnsa_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (cmd.div_row ? sh : sw),
      .denom (cmd.div_row ? dh : dw),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   assign status.div_done = div_done;

   assign skip_prod = row_quot_ff * sw;

   always_comb begin
      col_whole_in = cmd.load_col  ? div_quot : col_whole_ff;
      col_rem_in   = cmd.load_col  ? div_rem  : col_rem_ff;
      row_rem_in   = cmd.load_row  ? div_rem  : row_rem_ff;
      row_quot_in  = cmd.load_row  ? div_quot : row_quot_ff;
      row_skip_in  = cmd.load_skip ? (skip_prod[OFF_W-1:0] - OFF_W'(sw)) : row_skip_ff;
   end

   // walk step
   always_comb begin
      cur_off  = cmd.clear ? '0 : off_ff;
      cur_col  = cmd.clear ? '0 : col_ff;
      cur_row  = cmd.clear ? '0 : row_ff;
      cur_cerr = cmd.clear ? '0 : cerr_ff;
      cur_rerr = cmd.clear ? '0 : rerr_ff;

      row_end = ({1'b0, cur_col} == (dw - DIM_W'(1)));
      last    = row_end && ({1'b0, cur_row} == (dh - DIM_W'(1)));

      cerr_sum = cur_cerr + col_rem_ff;
      cc       = (cerr_sum >= dw);
      rerr_sum = cur_rerr + row_rem_ff;
      rc       = (rerr_sum >= dh);

      off_sum = cur_off + OFF_W'(col_whole_ff) + OFF_W'(cc)
              + (row_end ? row_skip_ff : '0)
              + ((row_end && rc) ? OFF_W'(sw) : '0);

      off_in  = off_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      cerr_in = cerr_ff;
      rerr_in = rerr_ff;
      if (cmd.step) begin
         if (last) begin
            off_in  = '0;
            col_in  = '0;
            row_in  = '0;
            cerr_in = '0;
            rerr_in = '0;
         end else if (row_end) begin
            off_in  = off_sum;
            col_in  = '0;
            row_in  = cur_row + COORD_W'(1);
            cerr_in = '0;
            rerr_in = rc ? (rerr_sum - dh) : rerr_sum;
         end else begin
            off_in  = off_sum;
            col_in  = cur_col + COORD_W'(1);
            row_in  = cur_row;
            cerr_in = cc ? (cerr_sum - dw) : cerr_sum;
            rerr_in = cur_rerr;
         end
      end

      idx_in  = cmd.step ? cur_off[IDX_W-1:0] : idx_ff;
      dx_in   = cmd.step ? cur_col : dx_ff;
      dy_in   = cmd.step ? cur_row : dy_ff;
      last_in = cmd.step ? last : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_whole_ff <= DIM_W'(1);
         col_rem_ff   <= '0;
         row_rem_ff   <= '0;
         row_skip_ff  <= '0;
         off_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         cerr_ff      <= '0;
         rerr_ff      <= '0;
      end else begin
         col_whole_ff <= col_whole_in;
         col_rem_ff   <= col_rem_in;
         row_rem_ff   <= row_rem_in;
         row_skip_ff  <= row_skip_in;
         off_ff       <= off_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cerr_ff      <= cerr_in;
         rerr_ff      <= rerr_in;
      end
      row_quot_ff <= row_quot_in;
      idx_ff      <= idx_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      last_ff     <= last_in;
   end

   assign source_index = idx_ff;
   assign dest_x       = dx_ff;
   assign dest_y       = dy_ff;
   assign last_pixel   = last_ff;

endmodule

// File: src/nnsa_ctrl.sv
// ----------------------------------------------------------------------------
// nnsa_ctrl
// sequencer for restart divisions and the request / result handshakes
// ----------------------------------------------------------------------------
module nnsa_ctrl
   import nnsa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_restart,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output nnsa_cmd_type    cmd,
   input  nnsa_status_type status,
   output logic            idle
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DIV_COL = 3'd1;
   localparam logic [2:0] ST_DIV_ROW = 3'd2;
   localparam logic [2:0] ST_MUL     = 3'd3;
   localparam logic [2:0] ST_EMIT    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idle      = (state_ff == ST_IDLE);
   assign req_stall = !(idle && out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_restart) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV_COL;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         ST_DIV_COL: begin
            if (status.div_done) begin
               cmd.load_col  = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_row   = 1'b1;
               state_in      = ST_DIV_ROW;
            end
         end
         ST_DIV_ROW: begin
            // divisor must stay on the row axis for every iteration
            cmd.div_row = 1'b1;
            if (status.div_done) begin
               cmd.load_row = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.load_skip = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.step  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/nearest_neighbor_scale_addr_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_addr_unit
// source-address generator for nearest-neighbour image resizing
// ----------------------------------------------------------------------------
// Each request yields one result: the raster index of the source pixel to
// copy for the next destination pixel in raster order, its destination
// column and row, and a flag on the final pixel, after which the walk wraps
// to pixel 0. An advance request (restart low) gives its result in the cycle
// after acceptance, and requests stream back to back at one per cycle while
// results are taken. A restart request recomputes the per-axis whole and
// remainder steps with a shared 13-step restoring divider, two divisions one
// after the other, then a multiply state for the row skip, and no request is
// taken until the result has been issued from the emit state. Image sizes are
// set through the csr port (source width, source height, destination width,
// destination height at byte addresses 0, 4, 8 and 12); zero is read as one
// and larger sizes saturate at 4096. Sizes should only be changed while the
// block is idle; the steps stay as latched at the last restart.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_addr_unit
   import nnsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_restart,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [IDX_W-1:0]   rsp_source_index,
   output logic [COORD_W-1:0] rsp_dest_x,
   output logic [COORD_W-1:0] rsp_dest_y,
   output logic               rsp_last_pixel,
   // configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // size registers, raw values as written
   logic [DIM_W-1:0] src_width_ff, src_width_in;
   logic [DIM_W-1:0] src_height_ff, src_height_in;
   logic [DIM_W-1:0] dst_width_ff, dst_width_in;
   logic [DIM_W-1:0] dst_height_ff, dst_height_in;

   logic             csr_wr;
   logic [1:0]       csr_idx;
   logic [DIM_W-1:0] csr_rd_val;

   nnsa_cmd_type     cmd;
   nnsa_status_type  status;
   logic             ctrl_idle;

   // zero wait states, word index from the upper address bits
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      dst_width_in  = dst_width_ff;
      dst_height_in = dst_height_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_SRC_WIDTH:  src_width_in  = csr_pwdata[DIM_W-1:0];
            REG_SRC_HEIGHT: src_height_in = csr_pwdata[DIM_W-1:0];
            REG_DST_WIDTH:  dst_width_in  = csr_pwdata[DIM_W-1:0];
            REG_DST_HEIGHT: dst_height_in = csr_pwdata[DIM_W-1:0];
            default:        src_width_in  = src_width_ff;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_idx)
         REG_SRC_WIDTH:  csr_rd_val = src_width_ff;
         REG_SRC_HEIGHT: csr_rd_val = src_height_ff;
         REG_DST_WIDTH:  csr_rd_val = dst_width_ff;
         REG_DST_HEIGHT: csr_rd_val = dst_height_ff;
         default:        csr_rd_val = '0;
      endcase
   end

   assign csr_prdata = {{(32-DIM_W){1'b0}}, csr_rd_val};

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= DIM_W'(1);
         src_height_ff <= DIM_W'(1);
         dst_width_ff  <= DIM_W'(1);
         dst_height_ff <= DIM_W'(1);
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         dst_width_ff  <= dst_width_in;
         dst_height_ff <= dst_height_in;
      end
   end

   // sequencer: restart divisions, handshakes, walk commands
   nnsa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .status      (status),
      .idle        (ctrl_idle)
   );

   // steps, walk state and result register
   nnsa_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .src_width    (src_width_ff),
      .src_height   (src_height_ff),
      .dst_width    (dst_width_ff),
      .dst_height   (dst_height_ff),
      .source_index (rsp_source_index),
      .dest_x       (rsp_dest_x),
      .dest_y       (rsp_dest_y),
      .last_pixel   (rsp_last_pixel)
   );

   // a restart keeps the block busy on the following cycle
   a_restart_busy : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_restart) |=> (req_stall && !ctrl_idle))
      else $error("restart request did not start the division sequence");

   // a new result never overwrites one that is still stalled
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!rsp_valid || !rsp_stall))
      else $error("result register loaded while a result was stalled");

   // the first pixel after a restart is the image origin
   a_restart_origin : assert property (@(posedge clock) disable iff (reset)
      (cmd.step && cmd.clear) |=>
         (rsp_valid && rsp_dest_x == '0 && rsp_dest_y == '0 && rsp_source_index == '0))
      else $error("restart result is not pixel 0");

   // the last-pixel flag sits on the final column of the destination row
   a_last_column : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_pixel) |->
         ({1'b0, rsp_dest_x} == (eff_dim(dst_width_ff) - DIM_W'(1))))
      else $error("last pixel flagged away from the final column");

endmodule

// File: dv/nearest_neighbor_scale_addr_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_addr_unit_tb
// self-checking bench for the nearest-neighbour source-address generator
// ----------------------------------------------------------------------------
// A short table of directed requests covers reset state, the size extremes,
// zero and oversize registers, advancing before any restart and sizes
// changed after a restart. Random phases follow: new image sizes over the
// csr port while idle, then streams of advance requests with occasional
// restarts. Every result is checked against a local model of the address
// walk or a typed-in table result. Back-pressure runs in three idling modes,
// plus one long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_addr_unit_tb;
   import nnsa_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]   source_index;
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
      logic               last_pixel;
   } pixel_type;

   // one row of the directed table
   typedef struct packed {
      logic                  load;     // write all four sizes first
      logic [3:0][DIM_W-1:0] sizes;    // indexed by register index
      logic                  restart;
      logic                  known;    // result typed in below
      pixel_type             want;
   } dir_entry_type;

   typedef enum {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_type;

   localparam int DIR_ROWS      = 25;
   localparam int MODE_ITEMS    = 530;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 50;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [IDX_W-1:0]   rsp_source_index;
   logic [COORD_W-1:0] rsp_dest_x;
   logic [COORD_W-1:0] rsp_dest_y;
   logic               rsp_last_pixel;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   nearest_neighbor_scale_addr_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_source_index (rsp_source_index),
      .rsp_dest_x       (rsp_dest_x),
      .rsp_dest_y       (rsp_dest_y),
      .rsp_last_pixel   (rsp_last_pixel),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // address walk model: size registers as written, steps latched at
   // restart, walk position and error terms
   // ------------------------------------------------------------------
   logic [3:0][DIM_W-1:0] size_reg = {4{DIM_W'(1)}};
   logic [OFF_W-1:0]   walk_offset   = '0;
   logic [COORD_W-1:0] walk_col      = '0;
   logic [COORD_W-1:0] walk_row      = '0;
   logic [DIM_W-1:0]   walk_col_err  = '0;
   logic [DIM_W-1:0]   walk_row_err  = '0;
   logic [DIM_W-1:0]   step_whole    = DIM_W'(1);
   logic [DIM_W-1:0]   step_col_rem  = '0;
   logic [DIM_W-1:0]   step_row_rem  = '0;
   logic [OFF_W-1:0]   row_skip      = '0;

   pixel_type pending_pixels[$];   // results still owed by the block
   int     mismatch_count = 0;

   int     req_idle_pct = 0;
   int     rsp_idle_pct = 0;
   logic   hold_arm = 1'b0;
   logic   hold_taken = 1'b0;
   int     hold_left = 0;

   dir_entry_type dir_table [DIR_ROWS];

   // zero reads as one, oversize saturates at the coordinate range
   function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v);
      if (v == '0) return DIM_W'(1);
      if (v > DIM_W'(DIM_CAP)) return DIM_W'(DIM_CAP);
      return v;
   endfunction

   function automatic void clear_walk();
      walk_offset  = '0;
      walk_col     = '0;
      walk_row     = '0;
      walk_col_err = '0;
      walk_row_err = '0;
   endfunction

   // emit the current pixel, then move the walk on by one
   function automatic pixel_type advance_walk(input logic restart);
      logic [DIM_W-1:0] sw, sh, dw, dh;
      logic [31:0]      skip_full;
      logic             row_end, last;
      pixel_type        px;
      sw = clamp_size(size_reg[REG_SRC_WIDTH]);
      sh = clamp_size(size_reg[REG_SRC_HEIGHT]);
      dw = clamp_size(size_reg[REG_DST_WIDTH]);
      dh = clamp_size(size_reg[REG_DST_HEIGHT]);
      if (restart) begin
         step_whole   = sw / dw;
         step_col_rem = sw % dw;
         step_row_rem = sh % dh;
         skip_full    = 32'(sh / dh) * 32'(sw) - 32'(sw);
         row_skip     = skip_full[OFF_W-1:0];
         clear_walk();
      end
      // destination sizes are read live, steps are not
      row_end = ({1'b0, walk_col} == dw - DIM_W'(1));
      last    = row_end && ({1'b0, walk_row} == dh - DIM_W'(1));
      px.source_index = walk_offset[IDX_W-1:0];
      px.dest_x       = walk_col;
      px.dest_y       = walk_row;
      px.last_pixel   = last;
      if (last) begin
         // wrap to pixel 0, steps kept
         clear_walk();
      end else begin
         walk_offset  = walk_offset + OFF_W'(step_whole);
         walk_col_err = walk_col_err + step_col_rem;
         if (walk_col_err >= dw) begin
            walk_col_err = walk_col_err - dw;
            walk_offset  = walk_offset + OFF_W'(1);
         end
         if (row_end) begin
            walk_col     = '0;
            walk_col_err = '0;
            walk_offset  = walk_offset + row_skip;
            walk_row_err = walk_row_err + step_row_rem;
            if (walk_row_err >= dh) begin
               walk_row_err = walk_row_err - dh;
               walk_offset  = walk_offset + OFF_W'(sw);
            end
            walk_row = walk_row + COORD_W'(1);
         end else begin
            walk_col = walk_col + COORD_W'(1);
         end
      end
      return px;
   endfunction

   // ------------------------------------------------------------------
   // result side: check against the oldest expectation, then pick the
   // stall for the next cycle (long hold-off takes priority)
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_type exp_px;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: result with nothing expected: index %h x %h y %h last %b",
                     $realtime, rsp_source_index, rsp_dest_x, rsp_dest_y, rsp_last_pixel);
            mismatch_count++;
         end else begin
            exp_px = pending_pixels.pop_front();
            if (rsp_source_index !== exp_px.source_index) begin
               $display("%0t: source_index expected %h actual %h",
                        $realtime, exp_px.source_index, rsp_source_index);
               mismatch_count++;
            end
            if (rsp_dest_x !== exp_px.dest_x) begin
               $display("%0t: dest_x expected %h actual %h",
                        $realtime, exp_px.dest_x, rsp_dest_x);
               mismatch_count++;
            end
            if (rsp_dest_y !== exp_px.dest_y) begin
               $display("%0t: dest_y expected %h actual %h",
                        $realtime, exp_px.dest_y, rsp_dest_y);
               mismatch_count++;
            end
            if (rsp_last_pixel !== exp_px.last_pixel) begin
               $display("%0t: last_pixel expected %b actual %b",
                        $realtime, exp_px.last_pixel, rsp_last_pixel);
               mismatch_count++;
            end
         end
      end
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_arm && !hold_taken) begin
         // long hold-off while the sender keeps offering requests
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // offer one request, optionally after idle cycles; valid stays high after
   // acceptance so back-to-back requests never drop it within a step
   task automatic send_request(input logic restart, input logic known, input pixel_type want);
      pixel_type px;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      px = advance_walk(restart);
      pending_pixels.push_back(known ? want : px);
   endtask

   // drop valid and let every owed result come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // apb writes of the selected size registers, back to back
   task automatic write_sizes(input logic [3:0] mask, input logic [3:0][DIM_W-1:0] vals);
      logic [1:0] reg_idx;
      for (int i = 0; i < 4; i++) begin
         reg_idx = 2'(i);
         if (mask[i]) begin
            // setup phase; bits above the register are junk on purpose
            csr_psel    <= 1'b1;
            csr_penable <= 1'b0;
            csr_pwrite  <= 1'b1;
            csr_paddr   <= {reg_idx, 2'b00};
            csr_pwdata  <= {19'($urandom()), vals[reg_idx]};
            @(posedge clock);
            // access phase
            csr_penable <= 1'b1;
            @(posedge clock);
            while (!csr_pready) @(posedge clock);
            size_reg[reg_idx] = vals[reg_idx];
         end
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic dir_entry_type dir_entry(
      input logic load, input logic [DIM_W-1:0] sw, sh, dw, dh,
      input logic restart, input logic known,
      input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] x, y, input logic last);
      dir_entry_type e;
      e.load                  = load;
      e.sizes[REG_SRC_WIDTH]  = sw;
      e.sizes[REG_SRC_HEIGHT] = sh;
      e.sizes[REG_DST_WIDTH]  = dw;
      e.sizes[REG_DST_HEIGHT] = dh;
      e.restart               = restart;
      e.known                 = known;
      e.want.source_index     = idx;
      e.want.dest_x           = x;
      e.want.dest_y           = y;
      e.want.last_pixel       = last;
      return e;
   endfunction

   // mostly small images so the walk wraps often, with rare extremes
   function automatic logic [DIM_W-1:0] pick_size(input bit is_dst);
      int sel;
      sel = $urandom_range(99);
      if (sel < 4) return '0;
      if (sel < 8) return DIM_W'($urandom_range(4097, 8191));
      if (sel < 11) return DIM_W'(4096);
      if (sel < 20) return DIM_W'($urandom_range(1, is_dst ? 64 : 4096));
      return DIM_W'($urandom_range(1, is_dst ? 12 : 300));
   endfunction

   initial begin
      // 1x1 image straight out of reset: every pixel is the last
      dir_table[0]  = dir_entry(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
      dir_table[1]  = dir_entry(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
      // advance with new sizes but no restart yet: reset steps apply
      dir_table[2]  = dir_entry(1, 5, 5, 3, 2, 0, 0, 0, 0, 0, 0);
      dir_table[3]  = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_table[4]  = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_table[5]  = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // restart mid-walk, then a downscale with remainders
      dir_table[6]  = dir_entry(0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0);
      dir_table[7]  = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_table[8]  = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_table[9]  = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // largest sizes, identity mapping
      dir_table[10] = dir_entry(1, 4096, 4096, 4096, 4096, 1, 1, 0, 0, 0, 0);
      dir_table[11] = dir_entry(0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0);
      // zero registers read as one
      dir_table[12] = dir_entry(1, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1);
      dir_table[13] = dir_entry(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
      // oversize source saturates, big whole steps and row skip
      dir_table[14] = dir_entry(1, 8191, 8191, 2, 2, 1, 0, 0, 0, 0, 0);
      dir_table[15] = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_table[16] = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_table[17] = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // upscale, negative row skip
      dir_table[18] = dir_entry(1, 3, 2, 7, 5, 1, 0, 0, 0, 0, 0);
      dir_table[19] = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_table[20] = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_table[21] = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_table[22] = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // destination width changed after restart: steps stay latched
      dir_table[23] = dir_entry(1, 3, 2, 9, 5, 0, 0, 0, 0, 0, 0);
      dir_table[24] = dir_entry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      idle_mode_type         mode;
      logic [3:0][DIM_W-1:0] vals;
      logic [3:0]            mask;
      int                    mode_items;
      int                    phase_len;
      bit                    first_phase;
      bit                    restart;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (dir_table[r].load) begin
            wait_idle();
            write_sizes(4'hF, dir_table[r].sizes);
         end
         send_request(dir_table[r].restart, dir_table[r].known, dir_table[r].want);
      end

      // random phases under three idling modes
      for (int m = 0; m < 3; m++) begin
         mode = idle_mode_type'(m);
         case (mode)
            IDLE_RX_HEAVY: begin
               req_idle_pct = 9;
               rsp_idle_pct <= 78;
            end
            IDLE_TX_HEAVY: begin
               req_idle_pct = 78;
               rsp_idle_pct <= 9;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct <= 0;
            end
         endcase
         mode_items  = 0;
         first_phase = 1'b1;
         while (mode_items < MODE_ITEMS) begin
            wait_idle();
            vals[REG_SRC_WIDTH]  = pick_size(1'b0);
            vals[REG_SRC_HEIGHT] = pick_size(1'b0);
            vals[REG_DST_WIDTH]  = pick_size(1'b1);
            vals[REG_DST_HEIGHT] = pick_size(1'b1);
            mask = 4'($urandom());
            if (mask == '0) mask = 4'hF;
            write_sizes(mask, vals);
            phase_len = $urandom_range(20, 80);
            if (mode == IDLE_NONE && first_phase) begin
               // fill the block behind a long receiver hold-off
               hold_arm <= 1'b1;
               phase_len = 150;
            end
            for (int k = 0; k < phase_len; k++) begin
               if (k == 0) restart = ($urandom_range(9) < 8) && !(mode == IDLE_NONE && first_phase);
               else restart = ($urandom_range(99) < 3);
               send_request(restart, 1'b0, '0);
            end
            mode_items += phase_len;
            first_phase = 1'b0;
         end
      end

      // drain, then watch for stray results
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS nearest_neighbor_scale_addr_unit");
      end else begin
         $display("FAIL nearest_neighbor_scale_addr_unit");
      end
      $finish;
   end

   // hung handshake or lost result
   initial begin
      #2000000;
      $display("FAIL nearest_neighbor_scale_addr_unit");
      $finish;
   end

endmodule

// File: sim.f
src/nnsa_pkg.sv
src/nnsa_div.sv
src/nnsa_dp.sv
src/nnsa_ctrl.sv
src/nearest_neighbor_scale_addr_unit.sv
dv/nearest_neighbor_scale_addr_unit_tb.sv
